### rtl/core/bit_unpack_widen_top_assert.svh
// Assertion macros for the bit unpack block.
// Both macros expect clk in scope; BUW_ASSERT also expects rst_n.
`ifndef BIT_UNPACK_WIDEN_TOP_ASSERT_SVH
`define BIT_UNPACK_WIDEN_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define BUW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BUW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BUW_ASSERT(lbl, prop, msg)
`define BUW_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/core/buw_pkg.sv
package buw_pkg;

  localparam int WORD_W    = 32;
  localparam int OFS_W     = 31;
  localparam int SCODE_W   = 2;
  localparam int DCODE_W   = 3;
  localparam int FIELD_W   = 8;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [DCODE_W-1:0] DCODE_MAX   = 3'd5;
  localparam logic [DCODE_W-1:0] DCODE_RESET = 3'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_ZERO = 2'd3;

  typedef struct packed {
    logic [SCODE_W-1:0] scode;
    logic [DCODE_W-1:0] dcode;     // after clamp and raise
    logic [OFS_W-1:0]   offset;
    logic               add_zero;
    logic               pass;      // equal widths, flag clear
  } cfg_t;

endpackage

### rtl/core/buw_if.sv
interface buw_in_if import buw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] src_word;
  logic              last_word;

  modport source (output valid, output src_word, output last_word, input ready);
  modport sink   (input valid, input src_word, input last_word, output ready);
endinterface

interface buw_out_if import buw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] dest_word;
  logic              last_out;

  modport source (output valid, output dest_word, output last_out, input ready);
  modport sink   (input valid, input dest_word, input last_out, output ready);
endinterface

### rtl/core/bit_unpack_widen_top.sv
// channel  | dir | payload                      | handshake
// in_ch    | in  | src_word[31:0], last_word    | valid/ready
// out_ch   | out | dest_word[31:0], last_out    | valid/ready
// cfg_*    | in  | cfg_addr[1:0], cfg_wdata[30:0]| cfg_we, no wait
// Each source item yields 2**(dst-src) result words, one per cycle unless out_ch
// stalls; the beat counter keeps the item in the input stage for all its words.
// With equal widths an item enters every cycle unless out_ch stalls.
// rst_n is synchronous; it loads the register defaults and empties both stages.
// A stalled out_ch holds the output register and backs up into in_ch.ready.
`include "bit_unpack_widen_top_assert.svh"

module bit_unpack_widen_top import buw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  buw_in_if.sink               in_ch,
  buw_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [OFS_W-1:0]     cfg_wdata
);

  // configuration
  logic [SCODE_W-1:0] src_code_r;
  logic [DCODE_W-1:0] dst_code_r;
  logic [OFS_W-1:0]   offset_r;
  logic               add_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_code_r <= '0;
      dst_code_r <= DCODE_RESET;
      offset_r   <= '0;
      add_zero_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SRC_CODE: src_code_r <= cfg_wdata[SCODE_W-1:0];
        REG_DST_CODE: dst_code_r <= cfg_wdata[DCODE_W-1:0];
        REG_OFFSET:   offset_r   <= cfg_wdata;
        REG_ADD_ZERO: add_zero_r <= cfg_wdata[0];
      endcase
    end
  end

  logic [DCODE_W-1:0] d_clamp;
  logic [DCODE_W-1:0] d_eff;
  logic [DCODE_W-1:0] diff;
  logic [CNT_W-1:0]   ratio_m1;
  cfg_t               cfg;

  always_comb begin
    d_clamp  = (dst_code_r > DCODE_MAX) ? DCODE_MAX : dst_code_r;
    d_eff    = (d_clamp < DCODE_W'(src_code_r)) ? DCODE_W'(src_code_r) : d_clamp;
    diff     = d_eff - DCODE_W'(src_code_r);
    ratio_m1 = CNT_W'((6'd1 << diff) - 6'd1);
    cfg.scode    = src_code_r;
    cfg.dcode    = d_eff;
    cfg.offset   = offset_r;
    cfg.add_zero = add_zero_r;
    cfg.pass     = (diff == '0) && !add_zero_r;
  end

  // input stage
  logic               a_valid_r;
  logic [CNT_W-1:0]   a_cnt_r;
  logic [WORD_W-1:0]  a_word_r;
  logic               a_last_r;
  logic [WORD_W-1:0]  a_word_nxt;

  // output register
  logic               o_valid_r;
  logic [WORD_W-1:0]  o_data_r;
  logic               o_last_r;

  logic               o_free;
  logic               beat;
  logic               a_done;
  logic               in_acc;
  logic [WORD_W-1:0]  dest;

  assign o_free = !o_valid_r || out_ch.ready;
  assign beat   = a_valid_r && o_free;
  assign a_done = beat && (a_cnt_r == '0);
  assign in_ch.ready = !a_valid_r || a_done;
  assign in_acc = in_ch.valid && in_ch.ready;

  // move the next group of source fields down to bit 0
  always_comb begin
    case (diff)
      3'd1:    a_word_nxt = a_word_r >> 16;
      3'd2:    a_word_nxt = a_word_r >> 8;
      3'd3:    a_word_nxt = a_word_r >> 4;
      3'd4:    a_word_nxt = a_word_r >> 2;
      3'd5:    a_word_nxt = a_word_r >> 1;
      default: a_word_nxt = a_word_r;
    endcase
  end

  buw_lane_pack u_pack (
    .word (a_word_r),
    .cfg  (cfg),
    .dest (dest)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_cnt_r   <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid_r <= 1'b1;
        a_cnt_r   <= ratio_m1;
      end else if (beat) begin
        if (a_cnt_r == '0) begin
          a_valid_r <= 1'b0;
        end else begin
          a_cnt_r <= a_cnt_r - 1'b1;
        end
      end
      if (beat) begin
        o_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_word_r <= in_ch.src_word;
      a_last_r <= in_ch.last_word;
    end else if (beat) begin
      a_word_r <= a_word_nxt;
    end
    if (beat) begin
      o_data_r <= dest;
      o_last_r <= a_last_r && (a_cnt_r == '0);
    end
  end

  assign out_ch.valid     = o_valid_r;
  assign out_ch.dest_word = o_data_r;
  assign out_ch.last_out  = o_last_r;

  `BUW_ASSERT_RST(a_rst_empty, !rst_n |=> !a_valid_r && !o_valid_r, "reset left a stage full")
  `BUW_ASSERT(a_cnt_idle, !a_valid_r |-> a_cnt_r == '0, "beat count set with empty stage")
  `BUW_ASSERT(a_ready_burst, in_ch.ready |-> a_cnt_r == '0, "ready raised mid burst")
  `BUW_ASSERT(a_cnt_step, beat && a_cnt_r != '0 && !in_acc |=> a_cnt_r == CNT_W'($past(a_cnt_r) - 1'b1), "beat count skipped")
  `BUW_ASSERT(a_last_early, beat && a_cnt_r != '0 |=> !o_last_r, "last flag before final beat")

endmodule

### rtl/core/buw_lane_pack.sv
// Builds one destination word from the low fields of a (pre-shifted) source word.
module buw_lane_pack import buw_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  cfg_t              cfg,
  output logic [WORD_W-1:0] dest
);

  logic [FIELD_W-1:0] fld [WORD_W];
  logic [WORD_W-1:0]  sum [WORD_W];
  logic [WORD_W-1:0]  acc;

  // one lane per possible field position
  always_comb begin
    for (int n = 0; n < WORD_W; n++) begin
      case (cfg.scode)
        2'd0:    fld[n] = FIELD_W'((word >> n) & 32'h1);
        2'd1:    fld[n] = FIELD_W'((word >> (2 * n)) & 32'h3);
        2'd2:    fld[n] = FIELD_W'((word >> (4 * n)) & 32'hF);
        default: fld[n] = FIELD_W'((word >> (8 * n)) & 32'hFF);
      endcase
      if (fld[n] != '0 || cfg.add_zero) begin
        sum[n] = WORD_W'(fld[n]) + {1'b0, cfg.offset};
      end else begin
        sum[n] = WORD_W'(fld[n]);
      end
    end
  end

  // carries spill into higher fields through the OR, bits past 31 drop
  always_comb begin
    acc = '0;
    case (cfg.dcode)
      3'd0: begin
        for (int n = 0; n < (WORD_W >> 0); n++) acc = acc | (sum[n] << n);
      end
      3'd1: begin
        for (int n = 0; n < (WORD_W >> 1); n++) acc = acc | (sum[n] << (n * 2));
      end
      3'd2: begin
        for (int n = 0; n < (WORD_W >> 2); n++) acc = acc | (sum[n] << (n * 4));
      end
      3'd3: begin
        for (int n = 0; n < (WORD_W >> 3); n++) acc = acc | (sum[n] << (n * 8));
      end
      3'd4: begin
        for (int n = 0; n < (WORD_W >> 4); n++) acc = acc | (sum[n] << (n * 16));
      end
      default: begin
        acc = sum[0];
      end
    endcase
  end

  assign dest = cfg.pass ? word : acc;

endmodule

### bench/widen_checker.sv
module widen_checker import buw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  buw_in_if                    in_ch,
  buw_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [OFS_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } dest_beat_t;

  dest_beat_t         dest_q[$];
  dest_beat_t         want;
  logic [SCODE_W-1:0] src_code;
  logic [DCODE_W-1:0] dst_code;
  logic [OFS_W-1:0]   offset;
  logic               add_zero;
  int                 errors = 0;
  int                 queued = 0;

  assign fail_count  = errors;
  assign outstanding = queued;

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // queues every destination word one source item produces
  function automatic void widen_word(logic [WORD_W-1:0] word, logic last);
    int unsigned       sc, dc, sbits, dbits, ratio, per_word, pos;
    logic [WORD_W-1:0] mask, acc, fld, rest;
    dest_beat_t        beat;
    sc = src_code;
    dc = dst_code;
    if (dc > DCODE_MAX) dc = DCODE_MAX;
    if (dc < sc) dc = sc;
    if (dc == sc && !add_zero) begin
      beat.word = word;
      beat.last = last;
      dest_q.push_back(beat);
      return;
    end
    sbits    = 1 << sc;
    dbits    = 1 << dc;
    mask     = (32'd1 << sbits) - 32'd1;
    ratio    = 1 << (dc - sc);
    per_word = WORD_W / dbits;
    rest     = word;
    for (int unsigned k = 0; k < ratio; k++) begin
      acc = '0;
      pos = 0;
      for (int unsigned n = 0; n < per_word; n++) begin
        fld = rest & mask;
        if (fld != '0 || add_zero) fld = fld + WORD_W'(offset);
        // carries spill into the next field; anything past bit 31 drops
        acc  = acc | (fld << pos);
        pos  = pos + dbits;
        rest = rest >> sbits;
      end
      beat.word = acc;
      beat.last = last && (k + 1 == ratio);
      dest_q.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      src_code = '0;
      dst_code = DCODE_RESET;
      offset   = '0;
      add_zero = 1'b0;
      dest_q.delete();
      queued   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SRC_CODE: src_code = cfg_wdata[SCODE_W-1:0];
          REG_DST_CODE: dst_code = cfg_wdata[DCODE_W-1:0];
          REG_OFFSET:   offset   = cfg_wdata;
          REG_ADD_ZERO: add_zero = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (dest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b",
                                    out_ch.dest_word, out_ch.last_out));
        end else begin
          want = dest_q.pop_front();
          if (out_ch.dest_word !== want.word)
            report_mismatch($sformatf("dest_word %h, want %h", out_ch.dest_word, want.word));
          if (out_ch.last_out !== want.last)
            report_mismatch($sformatf("last_out %b, want %b (word %h)",
                                      out_ch.last_out, want.last, want.word));
        end
      end
      if (in_ch.valid && in_ch.ready) widen_word(in_ch.src_word, in_ch.last_word);
      queued = dest_q.size();
    end
  end

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import buw_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [OFS_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   outstanding;
  int                   idle_pct;
  int                   stall_pct;
  int                   cycle_cnt = 0;

  buw_in_if  in_ch();
  buw_out_if out_ch();

  bit_unpack_widen_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  widen_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  // holds valid across back-to-back items; drops it only for a gap
  task automatic push_src(input logic [WORD_W-1:0] w, input logic l);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.src_word  <= w;
    in_ch.last_word <= l;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cfg(input logic [SCODE_W-1:0] s, input logic [DCODE_W-1:0] d,
                          input logic [OFS_W-1:0] o, input logic z);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SRC_CODE;
    cfg_wdata <= OFS_W'(s);
    @(posedge clk);
    cfg_addr  <= REG_DST_CODE;
    cfg_wdata <= OFS_W'(d);
    @(posedge clk);
    cfg_addr  <= REG_OFFSET;
    cfg_wdata <= o;
    @(posedge clk);
    cfg_addr  <= REG_ADD_ZERO;
    cfg_wdata <= OFS_W'(z);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return WORD_W'(1) << $urandom_range(WORD_W - 1);
      3: return $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] pick_offset();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return OFS_W'($urandom_range(255));
      default: return OFS_W'($urandom);
    endcase
  endfunction

  // bursts of items, each burst under a fresh setting
  task automatic run_phase(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      drain();
      load_cfg(SCODE_W'($urandom_range(3)), DCODE_W'($urandom_range(7)), pick_offset(),
               1'($urandom_range(1)));
      burst = $urandom_range(4, 24);
      for (int i = 0; i < burst; i++)
        push_src(pick_word(), (i == burst - 1) || ($urandom_range(7) == 0));
      sent += burst;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = REG_SRC_CODE;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.src_word  = '0;
    in_ch.last_word = 1'b0;
    idle_pct        = 27;
    stall_pct       = 82;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: 1-bit fields to 4-bit
    push_src(32'hFFFF_FFFF, 1'b0);
    push_src(32'h0000_0000, 1'b1);
    push_src(32'h8000_0001, 1'b0);
    // 1 to 32 with max offset on every field
    drain();
    load_cfg(2'd0, 3'd5, 31'h7FFF_FFFF, 1'b1);
    push_src(32'hA5A5_A5A5, 1'b1);
    // equal widths, flag clear: words pass untouched
    drain();
    load_cfg(2'd3, 3'd3, 31'd0, 1'b0);
    push_src(32'hDEAD_BEEF, 1'b0);
    push_src(32'h0000_0000, 1'b0);
    push_src(32'hFFFF_FFFF, 1'b1);
    // equal widths, flag set
    drain();
    load_cfg(2'd3, 3'd3, 31'd5, 1'b1);
    push_src(32'h00FF_80FB, 1'b1);
    // narrow destination gets raised, then passes
    drain();
    load_cfg(2'd2, 3'd1, 31'd3, 1'b0);
    push_src(32'h1234_5670, 1'b1);
    drain();
    load_cfg(2'd1, 3'd0, 31'h7FFF_FFFF, 1'b0);
    push_src(32'hFFFF_0000, 1'b1);
    // destination code past 32 bits
    drain();
    load_cfg(2'd1, 3'd7, 31'h55, 1'b0);
    push_src(32'h1B1B_0000, 1'b0);
    push_src(32'hFFFF_FFFF, 1'b1);
    drain();
    load_cfg(2'd2, 3'd6, 31'h4000_0000, 1'b0);
    push_src(32'hF0E1_D2C3, 1'b1);
    // sums that grow past the source field width
    drain();
    load_cfg(2'd3, 3'd4, 31'hFF, 1'b0);
    push_src(32'hFF00_FF01, 1'b0);
    push_src(32'h0102_FF80, 1'b1);
    drain();
    load_cfg(2'd0, 3'd1, 31'd1, 1'b1);
    push_src(32'h5555_AAAA, 1'b1);

    run_phase(110);
    idle_pct  = 82;
    stall_pct = 27;
    run_phase(110);
    idle_pct  = 0;
    stall_pct = 0;
    run_phase(110);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
